### rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN expression evaluator
// Token kinds, status codes and stack sizing.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    K_PUSH = 4'd0, K_ADD = 4'd1, K_SUB = 4'd2, K_MUL = 4'd3, K_DIV = 4'd4,
    K_NEG = 4'd5, K_IF = 4'd6, K_MIN = 4'd7, K_MAX = 4'd8
  } kind_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_STACK = 2'd2;

endpackage

### rtl/rpn_expression_evaluator.sv
`timescale 1ns / 1ps
// Division uses a 32-step bit-serial divider.
// One token at a time; the rate is set by one stack read per cycle and the
// bit-serial divider. A result beat is valid the cycle after the final token's emit.
// Output is a one-entry register: next token is taken while a result waits.
// Reset (rst_n low, synchronous) empties the stack and clears the fault;
// stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// rpn_expression_evaluator: postfix evaluator on a memory-held operand stack
// Sequencer reads operands from stack RAM, computes, writes the result back.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // [3:0] kind, [35:4] operand, [42:36] arg_count
  input  logic        in_tlast,  // last_token
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // [31:0] result_value, [33:32] status
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_DIV, S_WR, S_EMIT} state_t;

  state_t            state_r;
  logic [31:0]       mem [STACK_DEPTH];
  logic [31:0]       rdata_r;
  logic [SP_W-1:0]   sp_r;
  logic [1:0]        fault_r;
  logic [3:0]        kind_r;
  logic [6:0]        cnt_r;    // reads issued
  logic [6:0]        rcv_r;    // reads returned
  logic [6:0]        k_r;
  logic              last_r;
  logic [31:0]       a_r, b_r, c_r;
  logic [SP_W-1:0]   nsp_r;
  logic [31:0]       wval_r;
  logic [31:0]       q_r, rem_r, dvs_r;
  logic [5:0]        dstep_r;
  logic              dneg_r;
  logic              ovalid_r;
  logic [31:0]       oval_r;
  logic [1:0]        ost_r;
  logic [31:0]       top_r;
  logic              re_r;
  logic [ADDR_W-1:0] raddr;
  logic              re;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [3:0]        ikind;
  logic [6:0]        ik;
  logic              need_fault;
  logic [SP_W:0]     need;
  logic [32:0]       dtrial;

  assign ikind = in_tdata[3:0];
  assign ik = in_tdata[42:36];
  assign in_tready = (state_r == S_IDLE) && !(last_r && ovalid_r);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {6'd0, ost_r, oval_r};

  // operands needed by the incoming token
  always_comb begin
    unique case (ikind)
      K_ADD, K_SUB, K_MUL, K_DIV: need = (SP_W+1)'(2);
      K_NEG: need = (SP_W+1)'(1);
      K_IF: need = (SP_W+1)'(3);
      K_MIN, K_MAX: need = (SP_W+1)'(ik);
      default: need = '0;
    endcase
    if (ikind == K_PUSH)
      need_fault = (sp_r >= SP_W'(STACK_DEPTH));
    else if (ikind == K_MIN || ikind == K_MAX)
      need_fault = (ik == 7'd0) || (need > {1'b0, sp_r});
    else
      need_fault = (need > {1'b0, sp_r});
  end

  // read address walks up from the deepest operand to the top
  assign re = (state_r == S_RD) && (cnt_r < k_r);
  assign raddr = ADDR_W'(sp_r - SP_W'(k_r) + SP_W'(cnt_r));

  // stack memory, one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wval_r;
    if (re) rdata_r <= mem[raddr];
  end
  assign we = (state_r == S_WR);
  assign waddr = ADDR_W'(nsp_r - SP_W'(1));

  assign dtrial = {rem_r, a_r[31]} - {1'b0, dvs_r};

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r <= '0;
      fault_r <= ST_OK;
      ovalid_r <= 1'b0;
      last_r <= 1'b0;
      re_r <= 1'b0;
    end else begin
      re_r <= re;
      if (ovalid_r && out_tready && !(state_r == S_EMIT && last_r)) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            kind_r <= ikind;
            last_r <= in_tlast;
            cnt_r <= '0;
            rcv_r <= '0;
            k_r <= need[6:0];
            if (fault_r != ST_OK || ikind > K_MAX) begin
              state_r <= S_EMIT;
            end else if (need_fault) begin
              fault_r <= ST_STACK;
              state_r <= S_EMIT;
            end else if (ikind == K_PUSH) begin
              wval_r <= in_tdata[35:4];
              nsp_r <= sp_r + SP_W'(1);
              state_r <= S_WR;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          if (re) cnt_r <= cnt_r + 7'd1;
          if (re_r) begin
            rcv_r <= rcv_r + 7'd1;
            // shift in: c=top, b=next, a=third; min/max folds into c
            if (kind_r == K_MIN || kind_r == K_MAX) begin
              if (rcv_r == 7'd0) c_r <= rdata_r;
              else if ((kind_r == K_MIN) ? ($signed(rdata_r) < $signed(c_r))
                                         : ($signed(c_r) < $signed(rdata_r)))
                c_r <= rdata_r;
            end else begin
              c_r <= rdata_r;
              b_r <= c_r;
              a_r <= b_r;
            end
            if (rcv_r + 7'd1 == k_r) state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // registers: top in c, second in b, third in a
          nsp_r <= sp_r - SP_W'(k_r) + SP_W'(1);
          state_r <= S_WR;
          unique case (kind_r)
            K_ADD: wval_r <= b_r + c_r;
            K_SUB: wval_r <= b_r - c_r;
            K_MUL: wval_r <= b_r * c_r;
            K_NEG: wval_r <= 32'd0 - c_r;
            K_IF: wval_r <= ($signed(a_r) > 0) ? b_r : c_r;
            K_DIV: begin
              if (c_r == 32'd0) begin
                fault_r <= ST_DIV0;
                state_r <= S_EMIT;
              end else begin
                a_r <= b_r[31] ? 32'd0 - b_r : b_r;
                dvs_r <= c_r[31] ? 32'd0 - c_r : c_r;
                dneg_r <= b_r[31] ^ c_r[31];
                rem_r <= '0;
                q_r <= '0;
                dstep_r <= '0;
                state_r <= S_DIV;
              end
            end
            default: wval_r <= c_r;
          endcase
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          a_r <= {a_r[30:0], 1'b0};
          if (!dtrial[32]) begin
            rem_r <= dtrial[31:0];
            q_r <= {q_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[30:0], a_r[31]};
            q_r <= {q_r[30:0], 1'b0};
          end
          dstep_r <= dstep_r + 6'd1;
          if (dstep_r == 6'd31) begin
            wval_r <= dneg_r ? 32'd0 - {q_r[30:0], !dtrial[32]}
                             : {q_r[30:0], !dtrial[32]};
            state_r <= S_WR;
          end
        end
        S_WR: begin
          sp_r <= nsp_r;
          c_r <= wval_r;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1;
            if (fault_r != ST_OK) begin
              oval_r <= '0;
              ost_r <= fault_r;
            end else if (sp_r == '0) begin
              oval_r <= '0;
              ost_r <= ST_STACK;
            end else begin
              oval_r <= top_r;
              ost_r <= ST_OK;
            end
            sp_r <= '0;
            fault_r <= ST_OK;
            last_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // shadow of the top entry, kept so the final beat needs no extra read
  always_ff @(posedge clk) begin
    if (state_r == S_WR) top_r <= wval_r;
  end

  // assertions
  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && last_r && (!ovalid_r || out_tready)) |=>
      (sp_r == '0 && fault_r == ST_OK && out_tvalid)) else $error("end not cleared");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dstep_r < 6'd32) else $error("divider overrun");

endmodule
